// ----- sv/mipmap_box_downsample_chain_defines.svh -----
// Assertion macros used by the mipmap chain top level.
`ifndef MIPMAP_BOX_DOWNSAMPLE_CHAIN_DEFINES_SVH
`define MIPMAP_BOX_DOWNSAMPLE_CHAIN_DEFINES_SVH

// Check a condition on every clock edge outside reset.
`define MBD_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define MBD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define MBD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mbdc_pkg.sv -----
// Shared constants, types and helpers of the mipmap chain.
package mbdc_pkg;

    localparam int MAX_LOG2   = 10;
    localparam int MIN_LOG2   = 3;
    localparam int NUM_CELLS  = MAX_LOG2 - 2;
    localparam int CNT_W      = MAX_LOG2;
    localparam int ADDR_W     = MAX_LOG2 - 1;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = 4;
    localparam logic [3:0] RESET_LOG2 = 4'd8;

    typedef logic [31:0] t_pix;

    typedef struct packed {
        logic done;
        t_pix pix;
    } t_res;

    typedef struct packed {
        logic                  valid;
        logic                  alive;
        t_pix                  pix;
        logic [3:0]            cnt;
        t_res [NUM_CELLS-1:0]  res;
    } t_beat;

    typedef struct packed {
        logic [3:0]            cnt;
        t_res [NUM_CELLS-1:0]  res;
    } t_item;

    function automatic logic [3:0] eff_log2(input logic [3:0] v);
        logic [3:0] r;
        if (v < 4'(MIN_LOG2)) begin
            r = 4'(MIN_LOG2);
        end else if (v > 4'(MAX_LOG2)) begin
            r = 4'(MAX_LOG2);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- sv/mbdc_cell.sv -----
// One 2x2 box filter cell of the mipmap chain.
module mbdc_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [2:0]       i_stage,
    input  logic [3:0]       i_log2,
    input  logic             i_clear,
    input  mbdc_pkg::t_beat  i_beat,
    output mbdc_pkg::t_beat  o_beat
);

    logic [35:0]                    r_mem [mbdc_pkg::MEM_DEPTH];
    logic [35:0]                    r_rd;
    mbdc_pkg::t_pix                 r_left;
    logic [mbdc_pkg::CNT_W-1:0]     r_col, n_col;
    logic [mbdc_pkg::CNT_W-1:0]     r_row, n_row;
    mbdc_pkg::t_beat                r_beat, n_beat;

    logic                           active, go, col_end, row_end, emit, store, done;
    logic [3:0]                     lg;
    logic [10:0]                    wfull;
    logic [mbdc_pkg::CNT_W-1:0]     wmax;
    logic [35:0]                    pairs;
    mbdc_pkg::t_pix                 avg;
    logic [9:0]                     tot [4];

    assign active  = ({1'b0, i_stage} + 4'd3) <= i_log2;
    assign lg      = i_log2 - {1'b0, i_stage};
    assign wfull   = (11'd1 << lg) - 11'd1;
    assign wmax    = wfull[mbdc_pkg::CNT_W-1:0];
    assign col_end = r_col == wmax;
    assign row_end = r_row == wmax;
    assign go      = i_beat.valid & i_beat.alive & active;
    assign emit    = go & r_col[0] & r_row[0];
    assign store   = go & r_col[0] & ~r_row[0];
    assign done    = (({1'b0, i_stage} + 4'd3) == i_log2) & col_end & row_end;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            pairs[9*c +: 9] = {1'b0, r_left[8*c +: 8]} + {1'b0, i_beat.pix[8*c +: 8]};
            tot[c]          = {1'b0, r_rd[9*c +: 9]} + {1'b0, pairs[9*c +: 9]};
            avg[8*c +: 8]   = tot[c][9:2];
        end
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_clear) begin
            n_col = '0;
            n_row = '0;
        end else if (go) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_comb begin
        n_beat = i_beat;
        if (go && !(r_col[0] && r_row[0])) begin
            n_beat.alive = 1'b0;
        end
        if (emit) begin
            n_beat.pix               = avg;
            n_beat.res[i_stage].pix  = avg;
            n_beat.res[i_stage].done = done;
            n_beat.cnt               = i_beat.cnt + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store) begin
            r_mem[r_col[mbdc_pkg::CNT_W-1:1]] <= pairs;
        end
        r_rd <= r_mem[n_col[mbdc_pkg::CNT_W-1:1]];
        if (go && !r_col[0]) begin
            r_left <= i_beat.pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= '0;
            r_col  <= '0;
            r_row  <= '0;
        end else begin
            r_beat <= n_beat;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

    assign o_beat = r_beat;

endmodule

// ----- sv/mipmap_box_downsample_chain.sv -----
// Mipmap chain top level: filter cells, result queue and output serializer.
// Takes one base pixel per cycle when ready and gives each mip level pixel
// (levels 1 to size_log2-2) as a beat with its level. A pixel crosses the row
// of eight filter cells, each holding its own level's row store; the results
// of one pixel then wait in a 16-entry queue and leave one beat per cycle
// while m_axis_tready is high, lowest level first. Input is taken while queue
// entries plus pixels in the cells stay below 16. Write size_log2 only when idle.
module mipmap_box_downsample_chain (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,     // size_log2
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // channel_0, channel_1, channel_2, channel_3
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // out_channel_0 .. out_channel_3
    output logic        m_axis_tlast,
    output logic [4:0]  m_axis_tuser     // level[3:0], image_done[4]
);

`include "mipmap_box_downsample_chain_defines.svh"

    logic [3:0]                     r_size;
    logic [3:0]                     log2;
    logic [3:0]                     r_infl, n_infl;
    mbdc_pkg::t_item                r_fifo [mbdc_pkg::FIFO_DEPTH];
    logic [mbdc_pkg::FIFO_AW-1:0]   r_wp, r_rp;
    logic [mbdc_pkg::FIFO_AW:0]     r_cnt;
    logic [2:0]                     r_sub;
    mbdc_pkg::t_beat                w_beat [mbdc_pkg::NUM_CELLS+1];
    mbdc_pkg::t_item                head;
    logic                           in_acc, out_acc, push, pop, last, exit_v;

    assign log2    = mbdc_pkg::eff_log2(r_size);
    assign in_acc  = s_axis_tvalid & s_axis_tready;
    assign exit_v  = w_beat[mbdc_pkg::NUM_CELLS].valid;
    assign push    = exit_v & (w_beat[mbdc_pkg::NUM_CELLS].cnt != 4'd0);

    assign s_axis_tready = (5'({1'b0, r_infl}) + r_cnt) < 5'(mbdc_pkg::FIFO_DEPTH);

    always_comb begin
        w_beat[0]       = '0;
        w_beat[0].valid = in_acc;
        w_beat[0].alive = 1'b1;
        w_beat[0].pix   = s_axis_tdata;
    end

    for (genvar g = 0; g < mbdc_pkg::NUM_CELLS; g++) begin : g_cell
        mbdc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (3'(g)),
            .i_log2  (log2),
            .i_clear (i_cfg_we),
            .i_beat  (w_beat[g]),
            .o_beat  (w_beat[g+1])
        );
    end

    assign head          = r_fifo[r_rp];
    assign m_axis_tvalid = r_cnt != '0;
    assign out_acc       = m_axis_tvalid & m_axis_tready;
    assign last          = {1'b0, r_sub} == (head.cnt - 4'd1);
    assign pop           = out_acc & last;
    assign m_axis_tdata  = head.res[r_sub].pix;
    assign m_axis_tlast  = last;
    assign m_axis_tuser  = {head.res[r_sub].done, {1'b0, r_sub} + 4'd1};

    assign n_infl = r_infl + {3'd0, in_acc} - {3'd0, exit_v};

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp].cnt <= w_beat[mbdc_pkg::NUM_CELLS].cnt;
            r_fifo[r_wp].res <= w_beat[mbdc_pkg::NUM_CELLS].res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= mbdc_pkg::RESET_LOG2;
            r_infl <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_sub  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size <= i_cfg_wdata;
            end
            r_infl <= n_infl;
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp  <= r_rp + 1'b1;
                r_sub <= '0;
            end else if (out_acc) begin
                r_sub <= r_sub + 1'b1;
            end
            r_cnt <= r_cnt + {4'd0, push} - {4'd0, pop};
        end
    end

    `MBD_ASSERT(a_infl_max, r_infl <= 4'(mbdc_pkg::NUM_CELLS), "too many pixels in cells")
    `MBD_ASSERT_IMP(a_no_ovf, push && !pop, r_cnt < 5'(mbdc_pkg::FIFO_DEPTH), "queue overflow")
    `MBD_ASSERT_IMP(a_head_cnt, m_axis_tvalid, head.cnt != 4'd0 && {1'b0, r_sub} < head.cnt,
        "head entry holds no result at sub index")
    `MBD_ASSERT_NXT(a_cfg_idle, i_cfg_we, r_size == $past(i_cfg_wdata), "size write lost")

endmodule
